// File: design/pixel_stack_statistics_defines.svh
// Assertion macros for the pixel stack statistics block.
// Included by the top level only; depends on nothing.
`ifndef PIXEL_STACK_STATISTICS_DEFINES_SVH
`define PIXEL_STACK_STATISTICS_DEFINES_SVH

// same-cycle implication
`define PSS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PSS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/pss_pkg.sv
// Shared types and constants for the pixel stack statistics block.
// Used by pss_iter and pixel_stack_statistics; depends on nothing.
package pss_pkg;

    localparam int PIXEL_COUNT_DEF = 4096;
    localparam int IDX_W  = 12;
    localparam int VAL_W  = 8;
    localparam int SUM_W  = 16;
    localparam int SSQ_W  = 24;
    localparam int WORK_W = 48;
    localparam int DIV_W  = 16;
    localparam int REM_W  = 26;
    localparam int ROOT_W = 24;
    localparam int CNT_W  = 6;

    localparam logic [1:0] CFG_IMAGE_COUNT = 2'd0;
    localparam logic [1:0] CFG_MEAN_MODE   = 2'd1;
    localparam logic [1:0] CFG_STDDEV_MODE = 2'd2;

    localparam logic KIND_ACCUM = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    localparam logic [SSQ_W-1:0] ONE_Q88 = 24'd256;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_RD   = 10'b00_0000_0010,
        S_MEAN = 10'b00_0000_0100,
        S_MUL1 = 10'b00_0000_1000,
        S_MUL2 = 10'b00_0001_0000,
        S_MUL3 = 10'b00_0010_0000,
        S_MUL4 = 10'b00_0100_0000,
        S_VDIV = 10'b00_1000_0000,
        S_SQRT = 10'b01_0000_0000,
        S_FIN  = 10'b10_0000_0000
    } state_t;

    typedef struct packed {
        logic start;
        logic sqrt_op;
    } iter_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } iter_stat_t;

endpackage

// File: design/pss_iter.sv
// Shared iterative unit: restoring divide (one quotient bit per cycle)
// and digit-by-digit square root (one root bit per cycle). Uses pss_pkg.
module pss_iter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pss_pkg::iter_ctl_t            ctl,
    input  logic [pss_pkg::WORK_W-1:0]    operand,
    input  logic [pss_pkg::DIV_W-1:0]     divisor,
    output pss_pkg::iter_stat_t           stat,
    output logic [pss_pkg::WORK_W-1:0]    result
);
    logic                          run_reg;
    logic                          done_reg;
    logic                          sqrt_reg;
    logic [pss_pkg::CNT_W-1:0]     cnt_reg;
    logic [pss_pkg::WORK_W-1:0]    work_reg;
    logic [pss_pkg::REM_W-1:0]     rem_reg;
    logic [pss_pkg::ROOT_W-1:0]    root_reg;
    logic [pss_pkg::DIV_W-1:0]     div_reg;
    logic [26:0]                   a_op;
    logic [26:0]                   b_op;
    logic [26:0]                   diff;
    logic                          ge;

    // one compare-subtract shared by both operations
    always_comb begin
        if (sqrt_reg) begin
            a_op = {rem_reg[24:0], work_reg[47:46]};
            b_op = {1'b0, root_reg, 2'b01};
        end else begin
            a_op = {10'd0, rem_reg[15:0], work_reg[47]};
            b_op = {11'd0, div_reg};
        end
        ge   = (a_op >= b_op);
        diff = a_op - b_op;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                run_reg  <= 1'b1;
                sqrt_reg <= ctl.sqrt_op;
                cnt_reg  <= ctl.sqrt_op ? 6'd23 : 6'd47;
                work_reg <= operand;
                rem_reg  <= '0;
                root_reg <= '0;
                div_reg  <= divisor;
            end else if (run_reg) begin
                if (sqrt_reg) begin
                    rem_reg  <= ge ? diff[25:0] : a_op[25:0];
                    root_reg <= {root_reg[22:0], ge};
                    work_reg <= {work_reg[45:0], 2'b00};
                end else begin
                    rem_reg  <= {10'd0, (ge ? diff[15:0] : a_op[15:0])};
                    work_reg <= {work_reg[46:0], ge};
                end
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == '0) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = run_reg;
    assign stat.done = done_reg;
    assign result    = sqrt_reg ? {24'd0, root_reg} : work_reg;

endmodule

// File: design/pixel_stack_statistics.sv
// Accumulate item: memory read, then write back; next item accepted after that.
// Readout item: memory read, then result; mean mode adds a 48-bit divide, std deviation
// (image count above one) adds 4 multiply steps, a divide and a square root, all on one
// shared unit. Out-of-range index: accumulate item dropped, readout goes to result.
// Result is held in an output register; a new item is accepted only after it is loaded.
// Reset (synchronous, active low) clears control and config; the statistics memory
// is undefined until each pixel's first image is written.
module pixel_stack_statistics #(
    parameter int PIXEL_COUNT = pss_pkg::PIXEL_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [7:0]                    cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic [pss_pkg::IDX_W-1:0]     s_pixel_index,
    input  logic [pss_pkg::VAL_W-1:0]     s_sample_value,
    input  logic                          s_first_image,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pss_pkg::IDX_W-1:0]     m_out_index,
    output logic [pss_pkg::VAL_W-1:0]     m_min_value,
    output logic [pss_pkg::VAL_W-1:0]     m_max_value,
    output logic [pss_pkg::SUM_W-1:0]     m_sum_or_mean,
    output logic [pss_pkg::SSQ_W-1:0]     m_spread
);
    localparam int AW    = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int ENT_W = 2 * pss_pkg::VAL_W + pss_pkg::SUM_W + pss_pkg::SSQ_W;

    pss_pkg::state_t state_reg, state_next;

    logic [7:0]  img_cnt_reg;
    logic        mean_mode_reg;
    logic        stddev_mode_reg;

    logic [ENT_W-1:0] mem [PIXEL_COUNT];
    logic [ENT_W-1:0] rd_reg;
    logic [AW-1:0]    addr_reg;
    logic [AW-1:0]    in_addr;
    logic [31:0]      idx_wide;
    logic             in_range;
    logic             accept;

    logic                        kind_reg;
    logic [pss_pkg::IDX_W-1:0]   idx_reg;
    logic [pss_pkg::VAL_W-1:0]   val_reg;
    logic [15:0]                 vsq_reg;
    logic                        first_reg;

    logic [pss_pkg::VAL_W-1:0]   min_reg, max_reg;
    logic [pss_pkg::SUM_W-1:0]   sum_reg;
    logic [pss_pkg::SSQ_W-1:0]   ssq_reg;
    logic [pss_pkg::SUM_W-1:0]   mean_reg;
    logic [pss_pkg::SSQ_W-1:0]   spread_reg;
    logic [31:0]                 nq_reg;
    logic [31:0]                 d_reg;
    logic [39:0]                 mul_reg;
    logic [23:0]                 mul_a;
    logic [15:0]                 mul_b;

    logic [7:0]  n_val;
    logic        var_needed;

    logic [pss_pkg::VAL_W-1:0]   rd_min, rd_max;
    logic [pss_pkg::SUM_W-1:0]   rd_sum;
    logic [pss_pkg::SSQ_W-1:0]   rd_ssq;
    logic [16:0]                 sum_add;
    logic [24:0]                 ssq_add;
    logic [ENT_W-1:0]            wr_data;
    logic [24:0]                 mean_num;

    pss_pkg::iter_ctl_t          it_ctl;
    pss_pkg::iter_stat_t         it_stat;
    logic [pss_pkg::WORK_W-1:0]  it_operand;
    logic [pss_pkg::DIV_W-1:0]   it_divisor;
    logic [pss_pkg::WORK_W-1:0]  it_result;

    assign s_ready  = (state_reg == pss_pkg::S_IDLE);
    assign accept   = s_valid && s_ready;
    assign idx_wide = 32'(s_pixel_index);
    assign in_range = (idx_wide < 32'(PIXEL_COUNT));
    assign in_addr  = idx_wide[AW-1:0];

    assign n_val      = (img_cnt_reg == 8'd0) ? 8'd1 : img_cnt_reg;
    assign var_needed = stddev_mode_reg && (n_val > 8'd1);

    assign {rd_min, rd_max, rd_sum, rd_ssq} = rd_reg;
    assign sum_add  = {1'b0, rd_sum} + {9'd0, val_reg};
    assign ssq_add  = {1'b0, rd_ssq} + {9'd0, vsq_reg};
    assign mean_num = {1'b0, rd_sum, 8'd0} + {18'd0, n_val[7:1]};

    always_comb begin
        if (first_reg) begin
            wr_data = {val_reg, val_reg, 8'd0, val_reg, 8'd0, vsq_reg};
        end else begin
            wr_data = {((val_reg < rd_min) ? val_reg : rd_min),
                       ((val_reg > rd_max) ? val_reg : rd_max),
                       (sum_add[16] ? 16'hFFFF : sum_add[15:0]),
                       (ssq_add[24] ? 24'hFF_FFFF : ssq_add[23:0])};
        end
    end

    // statistics memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_reg <= mem[in_addr];
        end
        if (state_reg == pss_pkg::S_RD && kind_reg == pss_pkg::KIND_ACCUM) begin
            mem[addr_reg] <= wr_data;
        end
    end

    // shared multiplier operands
    always_comb begin
        case (state_reg)
            pss_pkg::S_MUL1: begin
                mul_a = ssq_reg;
                mul_b = {8'd0, n_val};
            end
            pss_pkg::S_MUL2: begin
                mul_a = {8'd0, sum_reg};
                mul_b = sum_reg;
            end
            default: begin
                mul_a = {16'd0, n_val};
                mul_b = {8'd0, n_val - 8'd1};
            end
        endcase
    end

    always_comb begin
        it_ctl.start   = 1'b0;
        it_ctl.sqrt_op = 1'b0;
        it_operand     = {23'd0, mean_num};
        it_divisor     = {8'd0, n_val};
        case (state_reg)
            pss_pkg::S_RD: begin
                it_ctl.start = (kind_reg == pss_pkg::KIND_READ) && mean_mode_reg;
            end
            pss_pkg::S_MUL4: begin
                it_ctl.start = 1'b1;
                it_operand   = {d_reg, 16'd0};
                it_divisor   = mul_reg[15:0];
            end
            pss_pkg::S_VDIV: begin
                it_ctl.start   = it_stat.done;
                it_ctl.sqrt_op = 1'b1;
                it_operand     = it_result;
            end
            default: begin
                it_ctl.start = 1'b0;
            end
        endcase
    end

    pss_iter u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (it_ctl),
        .operand (it_operand),
        .divisor (it_divisor),
        .stat    (it_stat),
        .result  (it_result)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pss_pkg::S_IDLE: begin
                if (accept) begin
                    if (in_range) begin
                        state_next = pss_pkg::S_RD;
                    end else if (s_kind == pss_pkg::KIND_READ) begin
                        state_next = pss_pkg::S_FIN;
                    end
                end
            end
            pss_pkg::S_RD: begin
                if (kind_reg == pss_pkg::KIND_ACCUM) begin
                    state_next = pss_pkg::S_IDLE;
                end else if (mean_mode_reg) begin
                    state_next = pss_pkg::S_MEAN;
                end else if (var_needed) begin
                    state_next = pss_pkg::S_MUL1;
                end else begin
                    state_next = pss_pkg::S_FIN;
                end
            end
            pss_pkg::S_MEAN: begin
                if (it_stat.done) begin
                    state_next = var_needed ? pss_pkg::S_MUL1 : pss_pkg::S_FIN;
                end
            end
            pss_pkg::S_MUL1: state_next = pss_pkg::S_MUL2;
            pss_pkg::S_MUL2: state_next = pss_pkg::S_MUL3;
            pss_pkg::S_MUL3: state_next = pss_pkg::S_MUL4;
            pss_pkg::S_MUL4: state_next = pss_pkg::S_VDIV;
            pss_pkg::S_VDIV: begin
                if (it_stat.done) begin
                    state_next = pss_pkg::S_SQRT;
                end
            end
            pss_pkg::S_SQRT: begin
                if (it_stat.done) begin
                    state_next = pss_pkg::S_FIN;
                end
            end
            pss_pkg::S_FIN: begin
                if (!m_valid || m_ready) begin
                    state_next = pss_pkg::S_IDLE;
                end
            end
            default: state_next = pss_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= pss_pkg::S_IDLE;
            img_cnt_reg     <= 8'd1;
            mean_mode_reg   <= 1'b0;
            stddev_mode_reg <= 1'b0;
            m_valid         <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    pss_pkg::CFG_IMAGE_COUNT: img_cnt_reg     <= cfg_data;
                    pss_pkg::CFG_MEAN_MODE:   mean_mode_reg   <= cfg_data[0];
                    pss_pkg::CFG_STDDEV_MODE: stddev_mode_reg <= cfg_data[0];
                    default:                  img_cnt_reg     <= img_cnt_reg;
                endcase
            end
            if (m_valid && m_ready) begin
                m_valid <= 1'b0;
            end
            if (state_reg == pss_pkg::S_FIN && (!m_valid || m_ready)) begin
                m_valid <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        mul_reg <= 40'(mul_a * mul_b);
        case (state_reg)
            pss_pkg::S_IDLE: begin
                kind_reg  <= s_kind;
                idx_reg   <= s_pixel_index;
                val_reg   <= s_sample_value;
                vsq_reg   <= s_sample_value * s_sample_value;
                first_reg <= s_first_image;
                addr_reg  <= in_addr;
                min_reg    <= '0;
                max_reg    <= '0;
                mean_reg   <= '0;
                spread_reg <= '0;
            end
            pss_pkg::S_RD: begin
                min_reg    <= rd_min;
                max_reg    <= rd_max;
                sum_reg    <= rd_sum;
                ssq_reg    <= rd_ssq;
                mean_reg   <= rd_sum;
                spread_reg <= stddev_mode_reg ? pss_pkg::ONE_Q88 : rd_ssq;
            end
            pss_pkg::S_MEAN: begin
                if (it_stat.done) begin
                    mean_reg <= (|it_result[47:16]) ? 16'hFFFF : it_result[15:0];
                end
            end
            pss_pkg::S_MUL2: nq_reg <= mul_reg[31:0];
            pss_pkg::S_MUL3: begin
                d_reg <= (nq_reg > mul_reg[31:0]) ? nq_reg - mul_reg[31:0] : 32'd0;
            end
            pss_pkg::S_SQRT: begin
                if (it_stat.done) begin
                    spread_reg <= it_result[23:0];
                end
            end
            pss_pkg::S_FIN: begin
                if (!m_valid || m_ready) begin
                    m_out_index   <= idx_reg;
                    m_min_value   <= min_reg;
                    m_max_value   <= max_reg;
                    m_sum_or_mean <= mean_reg;
                    m_spread      <= spread_reg;
                end
            end
            default: ;
        endcase
    end

`include "pixel_stack_statistics_defines.svh"

    `PSS_ASSERT_NEXT(a_bad_read_fin, aclk, aresetn, accept && !in_range && s_kind == pss_pkg::KIND_READ, state_reg == pss_pkg::S_FIN, "out-of-range readout did not go to result")
    `PSS_ASSERT_NEXT(a_acc_two_cycle, aclk, aresetn, state_reg == pss_pkg::S_RD && kind_reg == pss_pkg::KIND_ACCUM, state_reg == pss_pkg::S_IDLE, "accumulate item not finished in two cycles")
    `PSS_ASSERT_NOW(a_unit_idle_out, aclk, aresetn, state_reg == pss_pkg::S_IDLE || state_reg == pss_pkg::S_FIN, !it_stat.busy, "shared unit busy outside readout")
    `PSS_ASSERT_NOW(a_mean_mode, aclk, aresetn, state_reg == pss_pkg::S_MEAN, mean_mode_reg && kind_reg == pss_pkg::KIND_READ, "mean divide without mean mode")

endmodule
